FILE: rtl/core/mcss_pkg.sv
// Package for the mouse card soft-switch core.
// Holds the item, state and result types, switch codes and reset values.
// No dependencies.
package mcss_pkg;

    localparam logic [3:0]  SW_MODE   = 4'd2;
    localparam logic [3:0]  SW_REPORT = 4'd4;
    localparam logic [3:0]  SW_CLAMP  = 4'd7;
    localparam logic [3:0]  SW_HOME   = 4'd8;
    localparam logic [3:0]  SW_RESET  = 4'd12;

    localparam logic [7:0]  CLAMP_SEL_X = 8'd0;
    localparam logic [7:0]  CLAMP_SEL_Y = 8'd1;

    localparam int          MODE_ENABLE_BIT = 0;
    localparam int          MODE_VBLANK_BIT = 3;

    localparam logic [15:0] CLAMP_RESET_MAX = 16'd1023;
    localparam logic [3:0]  MODE_CLEARED    = 4'd0;

    typedef struct packed {
        logic        mode;
        logic [3:0]  switch_number;
        logic        write;
        logic [7:0]  data_byte;
        logic [15:0] pointer_x;
        logic [15:0] pointer_y;
        logic        button_now;
        logic [15:0] clamp_low_word;
        logic [15:0] clamp_high_word;
    } t_item;

    typedef struct packed {
        logic [3:0]  mode_nibble;
        logic        enable_flag;
        logic        vblank_enable;
        logic [15:0] position_x;
        logic [15:0] position_y;
        logic        button_state;
        logic [15:0] latched_x;
        logic [15:0] latched_y;
        logic        latched_button;
        logic [15:0] min_x;
        logic [15:0] max_x;
        logic [15:0] min_y;
        logic [15:0] max_y;
    } t_state;

    typedef struct packed {
        logic        report_valid;
        logic [15:0] report_x;
        logic [15:0] report_y;
        logic [7:0]  status_byte;
        logic        mode_write_valid;
        logic [3:0]  mode_value;
        logic        vblank_irq_enable;
        logic        mouse_enabled;
        logic [15:0] clamp_min_x;
        logic [15:0] clamp_max_x;
        logic [15:0] clamp_min_y;
        logic [15:0] clamp_max_y;
    } t_result;

    localparam t_state STATE_RESET = '{
        mode_nibble:    4'd0,
        enable_flag:    1'b0,
        vblank_enable:  1'b0,
        position_x:     16'd0,
        position_y:     16'd0,
        button_state:   1'b0,
        latched_x:      16'd0,
        latched_y:      16'd0,
        latched_button: 1'b0,
        min_x:          16'd0,
        max_x:          CLAMP_RESET_MAX,
        min_y:          16'd0,
        max_y:          CLAMP_RESET_MAX
    };

endpackage

FILE: rtl/core/mcss_step.sv
// Next-state and result logic for one transaction of the soft-switch core.
// Purely combinational; depends on mcss_pkg.
module mcss_step (
    input  mcss_pkg::t_state  i_state,
    input  mcss_pkg::t_item   i_item,
    output mcss_pkg::t_state  o_state,
    output mcss_pkg::t_result o_result
);

    mcss_pkg::t_state n_state;
    logic             rep;
    logic             mw;
    logic [3:0]       mw_val;
    logic             moved;

    always_comb begin
        n_state = i_state;
        rep     = 1'b0;
        mw      = 1'b0;
        mw_val  = mcss_pkg::MODE_CLEARED;
        moved   = (i_state.position_x != i_state.latched_x) ||
                  (i_state.position_y != i_state.latched_y);

        if (!i_item.mode) begin
            n_state.position_x   = i_item.pointer_x;
            n_state.position_y   = i_item.pointer_y;
            n_state.button_state = i_item.button_now;
        end else begin
            unique case (i_item.switch_number)
                mcss_pkg::SW_MODE: begin
                    if (i_item.write) begin
                        n_state.mode_nibble   = i_item.data_byte[3:0];
                        n_state.enable_flag   = i_item.data_byte[mcss_pkg::MODE_ENABLE_BIT];
                        n_state.vblank_enable = i_item.data_byte[mcss_pkg::MODE_VBLANK_BIT];
                        mw                    = 1'b1;
                        mw_val                = i_item.data_byte[3:0];
                    end
                end
                mcss_pkg::SW_REPORT: begin
                    if (i_state.enable_flag) begin
                        rep                    = 1'b1;
                        n_state.latched_x      = i_state.position_x;
                        n_state.latched_y      = i_state.position_y;
                        n_state.latched_button = i_state.button_state;
                    end
                end
                mcss_pkg::SW_CLAMP: begin
                    if (i_item.data_byte == mcss_pkg::CLAMP_SEL_X) begin
                        n_state.min_x = i_item.clamp_low_word;
                        n_state.max_x = i_item.clamp_high_word;
                    end else if (i_item.data_byte == mcss_pkg::CLAMP_SEL_Y) begin
                        n_state.min_y = i_item.clamp_low_word;
                        n_state.max_y = i_item.clamp_high_word;
                    end
                end
                mcss_pkg::SW_HOME: begin
                    n_state.position_x = i_state.min_x;
                    n_state.position_y = i_state.min_y;
                end
                mcss_pkg::SW_RESET: begin
                    n_state.min_x       = 16'd0;
                    n_state.min_y       = 16'd0;
                    n_state.max_x       = mcss_pkg::CLAMP_RESET_MAX;
                    n_state.max_y       = mcss_pkg::CLAMP_RESET_MAX;
                    n_state.enable_flag = 1'b0;
                    mw                  = 1'b1;
                    mw_val              = mcss_pkg::MODE_CLEARED;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_state = n_state;

    always_comb begin
        o_result                   = '0;
        o_result.report_valid      = rep;
        if (rep) begin
            o_result.report_x    = i_state.position_x;
            o_result.report_y    = i_state.position_y;
            o_result.status_byte = {i_state.button_state, i_state.latched_button, moved, 5'd0};
        end
        o_result.mode_write_valid  = mw;
        o_result.mode_value        = mw_val;
        o_result.vblank_irq_enable = n_state.vblank_enable;
        o_result.mouse_enabled     = n_state.enable_flag;
        o_result.clamp_min_x       = n_state.min_x;
        o_result.clamp_max_x       = n_state.max_x;
        o_result.clamp_min_y       = n_state.min_y;
        o_result.clamp_max_y       = n_state.max_y;
    end

endmodule

FILE: rtl/core/mouse_card_soft_switches_core.sv
// Mouse card soft-switch core: input register, step logic, result register.
// Each transaction passes through the input register, then the result register;
// throughput one transaction per cycle, limited only by the output stall.
// Reset (synchronous, active low) empties both registers and returns the
// switch state to mode 0, disabled, clamps 0..1023, pointer at origin.
// Depends on mcss_pkg and mcss_step.
module mouse_card_soft_switches_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [3:0]  i_switch_number,
    input  logic        i_write,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_pointer_x,
    input  logic [15:0] i_pointer_y,
    input  logic        i_button_now,
    input  logic [15:0] i_clamp_low_word,
    input  logic [15:0] i_clamp_high_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_report_valid,
    output logic [15:0] o_report_x,
    output logic [15:0] o_report_y,
    output logic [7:0]  o_status_byte,
    output logic        o_mode_write_valid,
    output logic [3:0]  o_mode_value,
    output logic        o_vblank_irq_enable,
    output logic        o_mouse_enabled,
    output logic [15:0] o_clamp_min_x,
    output logic [15:0] o_clamp_max_x,
    output logic [15:0] o_clamp_min_y,
    output logic [15:0] o_clamp_max_y
);

    logic               r_in_valid;
    mcss_pkg::t_item    r_in;
    mcss_pkg::t_state   r_state;
    logic               r_out_valid;
    mcss_pkg::t_result  r_out;

    mcss_pkg::t_state   n_state;
    mcss_pkg::t_result  n_out;
    logic               advance;
    logic               take;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign take    = i_valid && !o_stall;

    mcss_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= mcss_pkg::STATE_RESET;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in.mode            <= i_mode;
            r_in.switch_number   <= i_switch_number;
            r_in.write           <= i_write;
            r_in.data_byte       <= i_data_byte;
            r_in.pointer_x       <= i_pointer_x;
            r_in.pointer_y       <= i_pointer_y;
            r_in.button_now      <= i_button_now;
            r_in.clamp_low_word  <= i_clamp_low_word;
            r_in.clamp_high_word <= i_clamp_high_word;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_report_valid      = r_out.report_valid;
    assign o_report_x          = r_out.report_x;
    assign o_report_y          = r_out.report_y;
    assign o_status_byte       = r_out.status_byte;
    assign o_mode_write_valid  = r_out.mode_write_valid;
    assign o_mode_value        = r_out.mode_value;
    assign o_vblank_irq_enable = r_out.vblank_irq_enable;
    assign o_mouse_enabled     = r_out.mouse_enabled;
    assign o_clamp_min_x       = r_out.clamp_min_x;
    assign o_clamp_max_x       = r_out.clamp_max_x;
    assign o_clamp_min_y       = r_out.clamp_min_y;
    assign o_clamp_max_y       = r_out.clamp_max_y;

endmodule

FILE: rtl/core/mcss_checker.sv
// Port-level checks for the mouse card soft-switch core, with its bind.
// Depends on mouse_card_soft_switches_core port names only.
module mcss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_report_valid,
    input logic [15:0] o_report_x,
    input logic [15:0] o_report_y,
    input logic [7:0]  o_status_byte,
    input logic        o_mode_write_valid,
    input logic [3:0]  o_mode_value,
    input logic        o_mouse_enabled
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result transaction dropped while stalled");

    a_quiet_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_report_valid |->
            o_report_x == 16'd0 && o_report_y == 16'd0 && o_status_byte == 8'd0)
        else $error("report fields nonzero without a report");

    a_report_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_report_valid |-> o_mouse_enabled)
        else $error("report issued while mouse disabled");

    a_mode_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mode_write_valid |-> o_mouse_enabled == o_mode_value[0])
        else $error("enable flag disagrees with written mode");

    a_status_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status_byte[4:0] == 5'd0)
        else $error("unused status bits set");

endmodule

bind mouse_card_soft_switches_core mcss_checker u_mcss_checker (.*);

FILE: tb/sv/mouse_card_soft_switches_core_tb.sv
// Testbench for mouse_card_soft_switches_core: directed and random transactions
// checked one for one against a state predictor kept in the bench.
// Depends on mcss_pkg and the core RTL.
module mouse_card_soft_switches_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 750;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    mcss_pkg::t_item    bus_item = '0;
    logic               o_stall;
    logic               o_valid;
    mcss_pkg::t_result  card_out;

    mcss_pkg::t_state   card = mcss_pkg::STATE_RESET;
    mcss_pkg::t_result  expected_results[$];

    int          errors = 0;
    int          idle_cycles = 0;
    int          burst_left = 8;
    int          stall_tick = 0;
    int          items_in = 0;
    int          host_updates = 0;
    int          reports_seen = 0;
    int          mode_writes_seen = 0;

    mouse_card_soft_switches_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_mode              (bus_item.mode),
        .i_switch_number     (bus_item.switch_number),
        .i_write             (bus_item.write),
        .i_data_byte         (bus_item.data_byte),
        .i_pointer_x         (bus_item.pointer_x),
        .i_pointer_y         (bus_item.pointer_y),
        .i_button_now        (bus_item.button_now),
        .i_clamp_low_word    (bus_item.clamp_low_word),
        .i_clamp_high_word   (bus_item.clamp_high_word),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_report_valid      (card_out.report_valid),
        .o_report_x          (card_out.report_x),
        .o_report_y          (card_out.report_y),
        .o_status_byte       (card_out.status_byte),
        .o_mode_write_valid  (card_out.mode_write_valid),
        .o_mode_value        (card_out.mode_value),
        .o_vblank_irq_enable (card_out.vblank_irq_enable),
        .o_mouse_enabled     (card_out.mouse_enabled),
        .o_clamp_min_x       (card_out.clamp_min_x),
        .o_clamp_max_x       (card_out.clamp_max_x),
        .o_clamp_min_y       (card_out.clamp_min_y),
        .o_clamp_max_y       (card_out.clamp_max_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic mcss_pkg::t_result step_card(input mcss_pkg::t_item it);
        mcss_pkg::t_result r;
        logic              moved;
        r = '0;
        if (!it.mode) begin
            card.position_x   = it.pointer_x;
            card.position_y   = it.pointer_y;
            card.button_state = it.button_now;
        end else begin
            case (it.switch_number)
                mcss_pkg::SW_MODE: begin
                    if (it.write) begin
                        card.mode_nibble   = it.data_byte[3:0];
                        card.enable_flag   = card.mode_nibble[mcss_pkg::MODE_ENABLE_BIT];
                        card.vblank_enable = card.mode_nibble[mcss_pkg::MODE_VBLANK_BIT];
                        r.mode_write_valid = 1'b1;
                        r.mode_value       = card.mode_nibble;
                    end
                end
                mcss_pkg::SW_REPORT: begin
                    if (card.enable_flag) begin
                        moved = (card.position_x != card.latched_x) ||
                                (card.position_y != card.latched_y);
                        r.report_valid = 1'b1;
                        r.report_x     = card.position_x;
                        r.report_y     = card.position_y;
                        r.status_byte  = {card.button_state, card.latched_button, moved, 5'b0};
                        card.latched_x      = card.position_x;
                        card.latched_y      = card.position_y;
                        card.latched_button = card.button_state;
                    end
                end
                mcss_pkg::SW_CLAMP: begin
                    if (it.data_byte == mcss_pkg::CLAMP_SEL_X) begin
                        card.min_x = it.clamp_low_word;
                        card.max_x = it.clamp_high_word;
                    end else if (it.data_byte == mcss_pkg::CLAMP_SEL_Y) begin
                        card.min_y = it.clamp_low_word;
                        card.max_y = it.clamp_high_word;
                    end
                end
                mcss_pkg::SW_HOME: begin
                    card.position_x = card.min_x;
                    card.position_y = card.min_y;
                end
                mcss_pkg::SW_RESET: begin
                    card.min_x         = '0;
                    card.min_y         = '0;
                    card.max_x         = mcss_pkg::CLAMP_RESET_MAX;
                    card.max_y         = mcss_pkg::CLAMP_RESET_MAX;
                    card.enable_flag   = 1'b0;
                    r.mode_write_valid = 1'b1;
                    r.mode_value       = mcss_pkg::MODE_CLEARED;
                end
                default: ;
            endcase
        end
        r.vblank_irq_enable = card.vblank_enable;
        r.mouse_enabled     = card.enable_flag;
        r.clamp_min_x       = card.min_x;
        r.clamp_max_x       = card.max_x;
        r.clamp_min_y       = card.min_y;
        r.clamp_max_y       = card.max_y;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        mcss_pkg::t_result want;
        logic              accepted;
        accepted = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                accepted = 1'b1;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with none expected, actual %h", $time, card_out);
                end else begin
                    want = expected_results.pop_front();
                    check_field("report_valid", 16'(want.report_valid),
                                16'(card_out.report_valid));
                    check_field("report_x", want.report_x, card_out.report_x);
                    check_field("report_y", want.report_y, card_out.report_y);
                    check_field("status_byte", 16'(want.status_byte),
                                16'(card_out.status_byte));
                    check_field("mode_write_valid", 16'(want.mode_write_valid),
                                16'(card_out.mode_write_valid));
                    check_field("mode_value", 16'(want.mode_value),
                                16'(card_out.mode_value));
                    check_field("vblank_irq_enable", 16'(want.vblank_irq_enable),
                                16'(card_out.vblank_irq_enable));
                    check_field("mouse_enabled", 16'(want.mouse_enabled),
                                16'(card_out.mouse_enabled));
                    check_field("clamp_min_x", want.clamp_min_x, card_out.clamp_min_x);
                    check_field("clamp_max_x", want.clamp_max_x, card_out.clamp_max_x);
                    check_field("clamp_min_y", want.clamp_min_y, card_out.clamp_min_y);
                    check_field("clamp_max_y", want.clamp_max_y, card_out.clamp_max_y);
                end
            end
            if (i_valid && !o_stall) begin
                accepted = 1'b1;
                want = step_card(bus_item);
                expected_results.push_back(want);
                items_in++;
                if (!bus_item.mode) host_updates++;
                if (want.report_valid) reports_seen++;
                if (want.mode_write_valid) mode_writes_seen++;
            end
        end
        idle_cycles <= accepted ? 0 : idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("mouse_card_soft_switches_core: mismatch");
        $finish;
    end

    // receiver: repeats quiet, light random, heavy random, then periodic stalls
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_tick[7:6])
            2'd0: i_stall <= 1'b0;
            2'd1: i_stall <= ($urandom_range(0, 2) == 0);
            2'd2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= stall_tick[2];
        endcase
    end

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic send_item(input mcss_pkg::t_item it);
        @(negedge i_clk);
        bus_item <= it;
        i_valid  <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic mcss_pkg::t_item host_update(input logic [15:0] x,
                                                    input logic [15:0] y,
                                                    input logic b);
        mcss_pkg::t_item it;
        it.mode            = 1'b0;
        it.switch_number   = 4'($urandom());
        it.write           = 1'($urandom());
        it.data_byte       = 8'($urandom());
        it.pointer_x       = x;
        it.pointer_y       = y;
        it.button_now      = b;
        it.clamp_low_word  = 16'($urandom());
        it.clamp_high_word = 16'($urandom());
        return it;
    endfunction

    function automatic mcss_pkg::t_item bus_access(input logic [3:0] sw, input logic wr,
                                                   input logic [7:0] data,
                                                   input logic [15:0] lo,
                                                   input logic [15:0] hi);
        mcss_pkg::t_item it;
        it.mode            = 1'b1;
        it.switch_number   = sw;
        it.write           = wr;
        it.data_byte       = data;
        it.pointer_x       = 16'($urandom());
        it.pointer_y       = 16'($urandom());
        it.button_now      = 1'($urandom());
        it.clamp_low_word  = lo;
        it.clamp_high_word = hi;
        return it;
    endfunction

    function automatic mcss_pkg::t_item noise_item();
        mcss_pkg::t_item it;
        it = bus_access(4'($urandom()), 1'($urandom()), 8'($urandom()),
                        16'($urandom()), 16'($urandom()));
        it.mode = 1'($urandom());
        return it;
    endfunction

    function automatic mcss_pkg::t_item session_item();
        int          pick;
        logic [7:0]  data;
        logic [15:0] x;
        logic [15:0] y;
        pick = $urandom_range(0, 99);
        data = 8'($urandom());
        if (pick < 35) begin
            x = ($urandom_range(0, 1) != 0) ? 16'($urandom()) : 16'($urandom_range(0, 1023));
            y = ($urandom_range(0, 1) != 0) ? 16'($urandom()) : 16'($urandom_range(0, 1023));
            return host_update(x, y, 1'($urandom()));
        end
        if (pick < 65) return bus_access(mcss_pkg::SW_REPORT, 1'($urandom()), data,
                                         16'($urandom()), 16'($urandom()));
        if (pick < 72) begin
            if ($urandom_range(0, 4) != 0) data[mcss_pkg::MODE_ENABLE_BIT] = 1'b1;
            return bus_access(mcss_pkg::SW_MODE, 1'b1, data,
                              16'($urandom()), 16'($urandom()));
        end
        if (pick < 80) begin
            if ($urandom_range(0, 5) != 0) data = 8'($urandom_range(0, 1));
            return bus_access(mcss_pkg::SW_CLAMP, 1'($urandom()), data,
                              16'($urandom()), 16'($urandom()));
        end
        if (pick < 87) return bus_access(mcss_pkg::SW_HOME, 1'($urandom()), data,
                                         16'($urandom()), 16'($urandom()));
        if (pick < 90) return bus_access(mcss_pkg::SW_RESET, 1'($urandom()), data,
                                         16'($urandom()), 16'($urandom()));
        if (pick < 95) return bus_access(mcss_pkg::SW_MODE, 1'b0, data,
                                         16'($urandom()), 16'($urandom()));
        return noise_item();
    endfunction

    task automatic test_host_updates();
        send_item(host_update(16'h0000, 16'h0000, 1'b0));
        send_item(host_update(16'hFFFF, 16'hFFFF, 1'b1));
    endtask

    task automatic test_mode_switch();
        send_item(bus_access(mcss_pkg::SW_MODE, 1'b0, 8'hFF, 16'h0000, 16'h0000));
        send_item(bus_access(mcss_pkg::SW_REPORT, 1'b0, 8'h00, 16'h0000, 16'h0000));
        send_item(bus_access(mcss_pkg::SW_MODE, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_item(bus_access(mcss_pkg::SW_MODE, 1'b1, 8'h08, 16'h0000, 16'h0000));
        send_item(bus_access(mcss_pkg::SW_MODE, 1'b1, 8'h09, 16'h0000, 16'h0000));
    endtask

    task automatic test_report_switch();
        send_item(bus_access(mcss_pkg::SW_REPORT, 1'b0, 8'h00, 16'h0000, 16'h0000));
        send_item(bus_access(mcss_pkg::SW_REPORT, 1'b1, 8'hFF, 16'h0000, 16'h0000));
        send_item(host_update(16'h1234, 16'h5678, 1'b0));
        send_item(bus_access(mcss_pkg::SW_REPORT, 1'b0, 8'h00, 16'h0000, 16'h0000));
        send_item(bus_access(mcss_pkg::SW_REPORT, 1'b0, 8'h00, 16'h0000, 16'h0000));
    endtask

    task automatic test_clamp_home_reset();
        send_item(bus_access(mcss_pkg::SW_CLAMP, 1'b1, mcss_pkg::CLAMP_SEL_X,
                             16'h0000, 16'hFFFF));
        send_item(bus_access(mcss_pkg::SW_CLAMP, 1'b1, mcss_pkg::CLAMP_SEL_Y,
                             16'hFFFF, 16'h0000));
        send_item(bus_access(mcss_pkg::SW_CLAMP, 1'b1, 8'h02, 16'h5555, 16'hAAAA));
        send_item(bus_access(mcss_pkg::SW_CLAMP, 1'b0, 8'hFF, 16'hAAAA, 16'h5555));
        send_item(bus_access(mcss_pkg::SW_HOME, 1'b1, 8'h00, 16'h0000, 16'h0000));
        send_item(bus_access(mcss_pkg::SW_REPORT, 1'b0, 8'h00, 16'h0000, 16'h0000));
        send_item(bus_access(mcss_pkg::SW_RESET, 1'b1, 8'h00, 16'h0000, 16'h0000));
        send_item(bus_access(mcss_pkg::SW_REPORT, 1'b0, 8'h00, 16'h0000, 16'h0000));
    endtask

    task automatic test_other_switches();
        send_item(bus_access(4'd0, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_item(bus_access(4'd15, 1'b1, 8'h01, 16'h0001, 16'h0002));
        send_item(bus_access(4'd3, 1'b0, 8'h00, 16'h0000, 16'h0000));
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) wait_drained();
            send_item(($urandom_range(0, 4) == 0) ? noise_item() : session_item());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_host_updates();
        test_mode_switch();
        test_report_switch();
        test_clamp_home_reset();
        test_other_switches();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d transactions: %0d host updates, %0d reports, %0d mode writes",
                 items_in, host_updates, reports_seen, mode_writes_seen);
        if (errors == 0) begin
            $display("mouse_card_soft_switches_core: match");
        end else begin
            $display("%0d field errors", errors);
            $display("mouse_card_soft_switches_core: mismatch");
        end
        $finish;
    end

endmodule
